// ===== src/string_bucket_hash_core_defines.svh =====
// Assertion macros used by the checker file of the string bucket hash core.
`ifndef STRING_BUCKET_HASH_CORE_DEFINES_SVH
`define STRING_BUCKET_HASH_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define SBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define SBH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Like the first macro, but also checked while reset is asserted.
`define SBH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sbh_pkg.sv =====
`default_nettype none

package sbh_pkg;

    localparam int KEY_W     = 8;
    localparam int BUCKET_W  = 16;
    localparam int TSIZE_W   = 17;
    localparam int HASH_W    = 32;
    localparam int WBUF_W    = 24;

    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 17'd1024;

    localparam int FOLD_SHIFT  = 3;
    localparam int MIX_SHIFT_A = 11;
    localparam int MIX_SHIFT_B = 13;
    localparam int MIX_SHIFT_C = 23;

    // One quotient bit per division step.
    localparam int DIV_STEPS  = HASH_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_DIV,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic take_byte;
        logic take_empty;
        logic mix;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/sbh_ctrl.sv =====
`default_nettype none

module sbh_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_last,
    input  wire                  i_in_empty,
    output logic                 o_in_ready,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output sbh_pkg::t_dp_cmd     o_cmd,
    input  sbh_pkg::t_dp_status  i_status
);
    import sbh_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        accept     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                accept     = i_in_valid;
                if (accept) begin
                    if (i_in_empty) begin
                        o_cmd.take_empty = 1'b1;
                        n_state          = ST_PUSH;
                    end else begin
                        o_cmd.take_byte = 1'b1;
                        if (i_in_last) begin
                            n_state = ST_MIX;
                        end
                    end
                end
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/sbh_datapath.sv =====
`default_nettype none

module sbh_datapath #(
    parameter int INDEX_BITS = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_wr_en,
    input  wire  [sbh_pkg::TSIZE_W-1:0]       i_cfg_wr_data,
    input  wire  [sbh_pkg::KEY_W-1:0]         i_key_byte,
    input  wire                               i_last_byte,
    input  sbh_pkg::t_dp_cmd                  i_cmd,
    output sbh_pkg::t_dp_status               o_status,
    output logic [sbh_pkg::BUCKET_W-1:0]      o_bucket
);
    import sbh_pkg::*;

    localparam int MaskBits = (INDEX_BITS < BUCKET_W) ? INDEX_BITS : BUCKET_W;
    localparam logic [BUCKET_W-1:0] IndexMask = BUCKET_W'((33'd1 << MaskBits) - 33'd1);

    logic [TSIZE_W-1:0]  r_table_size;
    logic [HASH_W-1:0]   r_acc;
    logic [WBUF_W-1:0]   r_wbuf;
    logic [1:0]          r_cnt;
    logic [HASH_W-1:0]   r_dividend;
    logic [TSIZE_W-1:0]  r_rem;
    logic [STEP_W-1:0]   r_step;
    logic [BUCKET_W-1:0] r_bucket;

    logic [HASH_W-1:0]   word_v;
    logic [HASH_W-1:0]   fold_sum;
    logic [HASH_W-1:0]   mixed;
    logic [TSIZE_W:0]    trial;
    logic [TSIZE_W:0]    divisor;
    logic [TSIZE_W-1:0]  n_rem;

    // Pending bytes shift up as a new byte enters at the bottom; a partly
    // filled word is therefore already right-aligned when the key ends.
    assign word_v   = {r_wbuf, i_key_byte};
    assign fold_sum = r_acc + (word_v ^ (word_v >> FOLD_SHIFT));
    assign mixed    = (r_dividend + (r_dividend >> MIX_SHIFT_A))
                    + ((r_dividend >> MIX_SHIFT_B) + (r_dividend >> MIX_SHIFT_C));

    // Restoring division, one remainder bit per step.
    assign divisor = {1'b0, r_table_size};
    assign trial   = {r_rem, r_dividend[HASH_W-1]};
    always_comb begin
        if (trial >= divisor) begin
            n_rem = TSIZE_W'(trial - divisor);
        end else begin
            n_rem = trial[TSIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TSIZE_RESET;
            r_acc        <= '0;
            r_wbuf       <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_table_size <= i_cfg_wr_data;
            end
            if (i_cmd.take_empty || (i_cmd.take_byte && i_last_byte)) begin
                r_acc  <= '0;
                r_wbuf <= '0;
                r_cnt  <= '0;
            end else if (i_cmd.take_byte) begin
                if (r_cnt == 2'd3) begin
                    r_acc  <= fold_sum;
                    r_wbuf <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_wbuf <= word_v[WBUF_W-1:0];
                    r_cnt  <= r_cnt + 2'd1;
                end
            end
        end
    end

    // With a full word the fold goes into the accumulator and the leftover is
    // zero, otherwise the partial word is folded; either way the final sum is
    // the accumulator plus the fold of the current word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && i_last_byte) begin
            r_dividend <= fold_sum;
        end else if (i_cmd.mix) begin
            r_dividend <= mixed;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[HASH_W-2:0], 1'b0};
        end
        if (i_cmd.take_empty || i_cmd.mix) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
        end
        if (i_cmd.mix) begin
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.load_out) begin
            if (r_table_size == '0) begin
                r_bucket <= '0;
            end else begin
                r_bucket <= r_rem[BUCKET_W-1:0] & IndexMask;
            end
        end
    end

    assign o_status.div_done = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_bucket          = r_bucket;

endmodule

`default_nettype wire

// ===== src/string_bucket_hash_core.sv =====
// Sequence: a last key byte gives its bucket after the mix state, the division steps in ST_DIV
// and the output load; an empty key goes straight to the output load and gives bucket 0.
// Throughput: one key byte per cycle while idle; a key end closes the input through the serial
// divider and output load, an empty key through the output load, plus any stalled-word drain.
// Reset (i_rst_n, synchronous, active low) clears the partial key, empties the output
// register and sets the table size to 1024 buckets.
`default_nettype none

module string_bucket_hash_core #(
    parameter int INDEX_BITS = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Table size register.
    input  wire                               i_cfg_wr_en,
    input  wire  [sbh_pkg::TSIZE_W-1:0]       i_cfg_wr_data,
    // Key byte stream.
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [7:0]                        s_axis_tdata,  // [7:0] key_byte
    input  wire                               s_axis_tlast,  // last_byte
    input  wire  [0:0]                        s_axis_tuser,  // [0] empty_key
    // Bucket stream.
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [15:0]                       m_axis_tdata   // [15:0] bucket
);
    import sbh_pkg::*;

    // The controller sequences each key: bytes are taken one per cycle while
    // idle, and the marked last byte starts the mix and the bit-serial
    // remainder. The datapath holds the word packer, the accumulator, the
    // divider and the output word register.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_in_empty  (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // Key bytes may keep flowing while a finished bucket word waits in the
    // output register; only a key end waits for that register to drain.
    sbh_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_key_byte    (s_axis_tdata),
        .i_last_byte   (s_axis_tlast),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_bucket      (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== src/sbh_checker.sv =====
`default_nettype none
`include "string_bucket_hash_core_defines.svh"

module sbh_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        s_axis_tlast,
    input wire [0:0]  s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);

    // A waiting bucket word stays offered.
    `SBH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "bucket word dropped while stalled")

    // A waiting bucket word keeps its value.
    `SBH_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "bucket word changed while stalled")

    // A key end hands the input over to the hash sequence.
    `SBH_ASSERT_NEXT(a_key_end_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser[0]), !s_axis_tready, "input still open after key end")

    // A new bucket word only follows a cycle in which the input was closed.
    `SBH_ASSERT_SAME(a_out_after_busy, i_clk, i_rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready), "bucket word without preceding hash sequence")

    // Reset empties the output register.
    `SBH_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid, "bucket word valid after reset")

endmodule

bind string_bucket_hash_core sbh_checker u_sbh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
